/* rtl/core/fte_pkg.sv */
// Shared types, constants and helper functions for the Fourier trajectory evaluator.
// Holds the request and result structs, the quarter-wave sine table and the 1/h table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fte_pkg;

    // Sizing of the coefficient stores and the number formats
    localparam int MAX_JOINTS    = 8;
    localparam int MAX_HARMONICS = 8;
    localparam int PHASE_BITS    = 16;
    localparam int VALUE_WIDTH   = 32;
    localparam int JOINT_W       = 3;
    localparam int HARM_W        = 3;
    localparam int COUNT_W       = 4;
    localparam int COEF_DEPTH    = MAX_JOINTS * MAX_HARMONICS;
    localparam int COEF_AW       = JOINT_W + HARM_W;
    localparam int FREQ_W        = 31;
    localparam int CFG_IDX_W     = 2;

    // Trig table geometry
    localparam int TAB_BITS    = 8;
    localparam int INTERP_BITS = PHASE_BITS - TAB_BITS;
    localparam int TRIG_W      = 17;
    localparam int QS_ENTRIES  = 65;
    localparam logic [INTERP_BITS:0] INTERP_ONE = (INTERP_BITS + 1)'(1 << INTERP_BITS);
    localparam logic [PHASE_BITS-1:0] QUARTER_TURN = PHASE_BITS'(1 << (PHASE_BITS - 2));

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_JOINTS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HARMONICS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP     = 2'd3;

    // Configuration reset values
    localparam logic [COUNT_W-1:0] JOINTS_RESET    = 4'd6;
    localparam logic [COUNT_W-1:0] HARMONICS_RESET = 4'd5;
    localparam logic [FREQ_W-1:0]  FREQ_RESET      = 31'd41175;
    localparam logic [FREQ_W-1:0]  RECIP_RESET     = 31'd104305;

    // Request kinds
    localparam logic [1:0] KIND_EVAL  = 2'd0;
    localparam logic [1:0] KIND_SIN   = 2'd1;
    localparam logic [1:0] KIND_COS   = 2'd2;
    localparam logic [1:0] KIND_START = 2'd3;

    // Saturation bounds
    localparam logic signed [63:0] VAL_MAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] VAL_MIN = -VAL_MAX - 64'sd1;

    // Request and result payloads
    typedef struct packed {
        logic [1:0]                    kind;
        logic [JOINT_W-1:0]            joint;
        logic [HARM_W-1:0]             harmonic;
        logic signed [VALUE_WIDTH-1:0] load_value;
        logic [PHASE_BITS-1:0]         phase;
    } in_item_t;

    typedef struct packed {
        logic [JOINT_W-1:0]            out_joint;
        logic signed [VALUE_WIDTH-1:0] position;
        logic signed [VALUE_WIDTH-1:0] velocity;
        logic signed [VALUE_WIDTH-1:0] acceleration;
        logic                          last;
    } out_item_t;

    // A sine or cosine sample as sign and magnitude
    typedef struct packed {
        logic              neg;
        logic [TRIG_W-1:0] mag;
    } trig_t;

    // Per-term control that travels down the pipeline
    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [HARM_W-1:0]  harm;
        logic               first;
        logic               last_h;
        logic               last_j;
    } term_ctl_t;

    typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

    // Reciprocals of the harmonic numbers in Q16
    localparam logic [16:0] INV_H [MAX_HARMONICS] = '{
        17'd65536, 17'd32768, 17'd21845, 17'd16384,
        17'd13107, 17'd10923, 17'd9362,  17'd8192
    };

    // Quarter-wave sine table, built at elaboration by a Taylor series in Q30
    typedef logic [TRIG_W-1:0] qsine_tab_t [QS_ENTRIES];
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    function automatic qsine_tab_t build_qsine();
        qsine_tab_t  tab;
        logic [63:0] x;
        logic [63:0] sq;
        logic [63:0] t;
        for (int k = 0; k < QS_ENTRIES; k++) begin
            x  = (64'(k) * PI_Q30) >> 7;
            sq = (x * x) >> 30;
            t  = Q30_ONE;
            for (int n = 7; n >= 1; n--) begin
                t = Q30_ONE - (((sq * t) >> 30) / TAYLOR_DIV[n]);
            end
            tab[k] = TRIG_W'((((x * t) >> 30) + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    localparam qsine_tab_t QSINE = build_qsine();

    // Clamp a wide signed value into the result range
    function automatic logic signed [VALUE_WIDTH-1:0] sat_value(input logic signed [63:0] v);
        logic signed [VALUE_WIDTH-1:0] r;
        priority if (v > VAL_MAX) begin
            r = VAL_MAX[VALUE_WIDTH-1:0];
        end else if (v < VAL_MIN) begin
            r = VAL_MIN[VALUE_WIDTH-1:0];
        end else begin
            r = v[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fte_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the coefficient stores; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire                       re,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/fourier_trajectory_evaluator_top.sv */
// Top level of the Fourier trajectory evaluator: sequencer, term pipeline and output stage.
// Depends on fte_pkg and fte_ram.
//
// Usage. Requests arrive on in_valid/in_ready/in_data. A load request (sine or cosine
// coefficient, or start position) is stored in the cycle it is accepted and gives no
// result. An evaluate request gives one result per joint in use, joints in ascending
// order, on out_valid/out_ready/out_data, with last set on the final joint.
// Configuration is written through cfg_en/cfg_index/cfg_data; the user must write it
// only while the block is idle, as the block does not enforce this. Throughput: the
// sequencer issues one joint-harmonic term per cycle into a nine-stage pipeline,
// except while the output stalls. The next request is taken once the pipeline has
// drained, even while the final result still waits in the output register. A load
// does not enter the pipeline, so the block stays ready for the next request.
// Reset clears all coefficients and start positions to zero and restores the default
// configuration. When the receiver stalls, the whole pipeline and the sequencer freeze,
// so no term is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module fourier_trajectory_evaluator_top
    import fte_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_en,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [FREQ_W-1:0]      cfg_data,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_data,
    output logic                  out_valid,
    input  wire                   out_ready,
    output out_item_t             out_data
);

    localparam int TERM_W = 33;
    localparam int D_W    = 34;
    localparam int AT_W   = 37;
    localparam int PACC_W = 37;
    localparam int VACC_W = 37;
    localparam int AACC_W = 40;

    // Sine of a phase by table lookup and linear interpolation
    function automatic trig_t sine_lookup(input logic [PHASE_BITS-1:0] p);
        logic [TAB_BITS-1:0]    idx;
        logic [INTERP_BITS-1:0] f;
        logic [1:0]             quad;
        logic [5:0]             i;
        logic [TRIG_W-1:0]      ta;
        logic [TRIG_W-1:0]      tb;
        logic [25:0]            mix;
        trig_t                  r;
        idx  = p[PHASE_BITS-1 -: TAB_BITS];
        f    = p[INTERP_BITS-1:0];
        quad = idx[7:6];
        i    = idx[5:0];
        if (quad[0])
        begin
            ta = QSINE[7'd64 - {1'b0, i}];
            tb = QSINE[7'd63 - {1'b0, i}];
        end
        else
        begin
            ta = QSINE[{1'b0, i}];
            tb = QSINE[7'({1'b0, i} + 7'd1)];
        end
        mix = ta * (INTERP_ONE - {1'b0, f}) + tb * f + 26'd128;
        r.mag = mix[24:8];
        r.neg = quad[1];
        return r;
    endfunction

    // Value times a trig sample, rounded half away from zero
    function automatic logic signed [TERM_W-1:0] by_trig(input logic signed [31:0] v,
                                                         input trig_t t);
        logic [31:0]     vmag;
        logic [48:0]     prod;
        logic [48:0]     rnd;
        logic [TERM_W-1:0] rmag;
        logic            neg;
        vmag = v[31] ? 32'(-v) : v;
        prod = vmag * t.mag;
        rnd  = prod + 49'd32768;
        rmag = {1'b0, rnd[47:16]};
        neg  = v[31] ^ t.neg;
        return neg ? -signed'(rmag) : signed'(rmag);
    endfunction

    // Configuration registers
    logic [COUNT_W-1:0] joints_reg;
    logic [COUNT_W-1:0] harms_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic [FREQ_W-1:0]  recip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joints_reg <= JOINTS_RESET;
            harms_reg  <= HARMONICS_RESET;
            freq_reg   <= FREQ_RESET;
            recip_reg  <= RECIP_RESET;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                CFG_JOINTS:    joints_reg <= cfg_data[COUNT_W-1:0];
                CFG_HARMONICS: harms_reg  <= cfg_data[COUNT_W-1:0];
                CFG_FREQ:      freq_reg   <= cfg_data;
                CFG_RECIP:     recip_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Joint and harmonic counts forced into their legal range
    logic [COUNT_W-1:0] nj_lim;
    logic [COUNT_W-1:0] nh_lim;

    always_comb
    begin
        if (joints_reg == '0)
            nj_lim = COUNT_W'(1);
        else if (joints_reg > COUNT_W'(MAX_JOINTS))
            nj_lim = COUNT_W'(MAX_JOINTS);
        else
            nj_lim = joints_reg;
        if (harms_reg == '0)
            nh_lim = COUNT_W'(1);
        else if (harms_reg > COUNT_W'(MAX_HARMONICS))
            nh_lim = COUNT_W'(MAX_HARMONICS);
        else
            nh_lim = harms_reg;
    end

    // Handshake and global advance
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    logic        adv;
    logic        accept;
    logic        eval_accept;
    logic        pipe_busy;
    seq_state_t  state_reg;
    seq_state_t  state_next;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic f1_valid_reg, f2_valid_reg, f3_valid_reg;

    assign adv         = !out_valid_reg || out_ready;
    assign pipe_busy   = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg ||
                         s5_valid_reg || f1_valid_reg || f2_valid_reg || f3_valid_reg;
    assign in_ready    = (state_reg == SEQ_IDLE) && !pipe_busy;
    assign accept      = in_valid && in_ready;
    assign eval_accept = accept && (in_data.kind == KIND_EVAL);

    // Load requests: coefficient stores with valid bits, start positions in flops
    logic                      sin_we;
    logic                      cos_we;
    logic [COEF_AW-1:0]        waddr;
    logic                      sin_ok_reg [COEF_DEPTH];
    logic                      cos_ok_reg [COEF_DEPTH];
    logic signed [VALUE_WIDTH-1:0] q0_reg [MAX_JOINTS];

    assign sin_we = accept && (in_data.kind == KIND_SIN);
    assign cos_we = accept && (in_data.kind == KIND_COS);
    assign waddr  = {in_data.joint, in_data.harmonic};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < COEF_DEPTH; k++)
            begin
                sin_ok_reg[k] <= 1'b0;
                cos_ok_reg[k] <= 1'b0;
            end
            for (int k = 0; k < MAX_JOINTS; k++)
            begin
                q0_reg[k] <= '0;
            end
        end
        else
        begin
            if (sin_we)
                sin_ok_reg[waddr] <= 1'b1;
            if (cos_we)
                cos_ok_reg[waddr] <= 1'b1;
            if (accept && (in_data.kind == KIND_START))
                q0_reg[in_data.joint] <= in_data.load_value;
        end
    end

    // Term sequencer: walks harmonics within joints, one term per cycle while the output does not stall
    logic [JOINT_W-1:0]    j_reg, j_next;
    logic [HARM_W-1:0]     h_reg, h_next;
    logic [PHASE_BITS-1:0] phase_reg;
    logic                  term_last_h;
    logic                  term_last_j;
    logic                  issue;

    assign term_last_h = {1'b0, h_reg} == COUNT_W'(nh_lim - COUNT_W'(1));
    assign term_last_j = {1'b0, j_reg} == COUNT_W'(nj_lim - COUNT_W'(1));
    assign issue       = (state_reg == SEQ_RUN) && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            j_reg     <= '0;
            h_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            h_reg     <= h_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        h_next     = h_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (eval_accept)
                begin
                    state_next = SEQ_RUN;
                    j_next     = '0;
                    h_next     = '0;
                end
            end
            SEQ_RUN:
            begin
                if (adv)
                begin
                    if (term_last_h)
                    begin
                        h_next = '0;
                        j_next = JOINT_W'(j_reg + JOINT_W'(1));
                        if (term_last_j)
                            state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        h_next = HARM_W'(h_reg + HARM_W'(1));
                    end
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (eval_accept)
            phase_reg <= in_data.phase;
    end

    // Issue: harmonic phase and coefficient read
    logic [COUNT_W-1:0]            harm_num;
    logic [PHASE_BITS+COUNT_W-1:0] ph_full;
    term_ctl_t                     issue_ctl;
    logic [VALUE_WIDTH-1:0]        sin_rdata;
    logic [VALUE_WIDTH-1:0]        cos_rdata;

    assign harm_num = COUNT_W'({1'b0, h_reg} + COUNT_W'(1));
    assign ph_full  = phase_reg * harm_num;

    always_comb
    begin
        issue_ctl.joint  = j_reg;
        issue_ctl.harm   = h_reg;
        issue_ctl.first  = (h_reg == '0);
        issue_ctl.last_h = term_last_h;
        issue_ctl.last_j = term_last_j;
    end

    fte_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(COEF_DEPTH)) u_sin_ram (
        .clk   (clk),
        .we    (sin_we),
        .waddr (waddr),
        .wdata (in_data.load_value),
        .re    (adv),
        .raddr ({j_reg, h_reg}),
        .rdata (sin_rdata)
    );

    fte_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(COEF_DEPTH)) u_cos_ram (
        .clk   (clk),
        .we    (cos_we),
        .waddr (waddr),
        .wdata (in_data.load_value),
        .re    (adv),
        .raddr ({j_reg, h_reg}),
        .rdata (cos_rdata)
    );

    // Pipeline registers
    term_ctl_t             s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg;
    logic [PHASE_BITS-1:0] s1_ph_reg;
    logic                  s1_a_ok_reg, s1_b_ok_reg;
    trig_t                 s2_s_reg, s2_c_reg;
    logic signed [VALUE_WIDTH-1:0] s2_a_reg, s2_b_reg;
    logic signed [TERM_W-1:0] s3_as_reg, s3_bc_reg, s3_ac_reg, s3_bs_reg;
    logic signed [D_W-1:0]    s4_d_reg, s4_v_reg;
    logic signed [D_W-1:0]    s5_p_reg, s5_v_reg;
    logic signed [AT_W-1:0]   s5_a_reg;
    logic signed [PACC_W-1:0] pos_acc_reg;
    logic signed [VACC_W-1:0] vel_acc_reg;
    logic signed [AACC_W-1:0] acc_acc_reg;
    logic [JOINT_W-1:0]       f1_j_reg, f2_j_reg, f3_j_reg;
    logic                     f1_last_reg, f2_last_reg, f3_last_reg;
    logic                     f2_pneg_reg, f2_aneg_reg;
    logic [48:0]              f2_pp_plo_reg;
    logic [49:0]              f2_pp_phi_reg;
    logic [50:0]              f2_pp_alo_reg, f2_pp_ahi_reg;
    logic signed [VALUE_WIDTH-1:0] f2_vel_reg, f3_vel_reg;
    logic signed [52:0]       f3_pos_reg;
    logic signed [55:0]       f3_acc_reg;

    // Stage 2: sine and cosine samples, coefficient gating
    trig_t                         s2_s_next, s2_c_next;
    logic signed [VALUE_WIDTH-1:0] s2_a_next, s2_b_next;

    always_comb
    begin
        s2_s_next = sine_lookup(s1_ph_reg);
        s2_c_next = sine_lookup(PHASE_BITS'(s1_ph_reg + QUARTER_TURN));
        s2_a_next = s1_a_ok_reg ? signed'(sin_rdata) : '0;
        s2_b_next = s1_b_ok_reg ? signed'(cos_rdata) : '0;
    end

    // Stage 4: difference and velocity term
    logic signed [D_W-1:0] s4_d_next, s4_v_next;

    always_comb
    begin
        s4_d_next = D_W'(s3_as_reg) - D_W'(s3_bc_reg);
        s4_v_next = D_W'(s3_ac_reg) + D_W'(s3_bs_reg);
    end

    // Stage 5: position term scaled by 1/h, acceleration term times -h
    logic [D_W-2:0]          dmag;
    logic [D_W-1:0]          dneg_full;
    logic [49:0]             pprod;
    logic [49:0]             pround;
    logic [D_W-1:0]          prmag;
    logic [COUNT_W-1:0]      s4_harm;
    logic signed [COUNT_W:0] harm_s;
    logic signed [38:0]      aterm_w;
    logic signed [D_W-1:0]   s5_p_next;
    logic signed [AT_W-1:0]  s5_a_next;

    always_comb
    begin
        dneg_full = -s4_d_reg;
        dmag      = s4_d_reg[D_W-1] ? dneg_full[D_W-2:0] : s4_d_reg[D_W-2:0];
        pprod     = dmag * INV_H[s4_ctl_reg.harm];
        pround    = pprod + 50'd32768;
        prmag     = pround[49:16];
        s5_p_next = s4_d_reg[D_W-1] ? -signed'(prmag) : signed'(prmag);
        s4_harm   = COUNT_W'({1'b0, s4_ctl_reg.harm} + COUNT_W'(1));
        harm_s    = signed'({1'b0, s4_harm});
        aterm_w   = -(harm_s * s4_d_reg);
        s5_a_next = aterm_w[AT_W-1:0];
    end

    // Accumulators over the harmonics of one joint
    logic signed [PACC_W-1:0] pos_acc_next;
    logic signed [VACC_W-1:0] vel_acc_next;
    logic signed [AACC_W-1:0] acc_acc_next;

    always_comb
    begin
        pos_acc_next = (s5_ctl_reg.first ? PACC_W'(0) : pos_acc_reg) + PACC_W'(s5_p_reg);
        vel_acc_next = (s5_ctl_reg.first ? VACC_W'(0) : vel_acc_reg) + VACC_W'(s5_v_reg);
        acc_acc_next = (s5_ctl_reg.first ? AACC_W'(0) : acc_acc_reg) + AACC_W'(s5_a_reg);
    end

    // Final stage F2: magnitudes split into partial products with the frequency registers
    logic [PACC_W-1:0] pneg_full;
    logic [PACC_W-1:0] pmag;
    logic [AACC_W-1:0] aneg_full;
    logic [AACC_W-1:0] amag;
    logic [48:0]       pp_plo_next;
    logic [49:0]       pp_phi_next;
    logic [50:0]       pp_alo_next, pp_ahi_next;

    always_comb
    begin
        pneg_full   = -pos_acc_reg;
        pmag        = pos_acc_reg[PACC_W-1] ? pneg_full : pos_acc_reg;
        aneg_full   = -acc_acc_reg;
        amag        = acc_acc_reg[AACC_W-1] ? aneg_full : acc_acc_reg;
        pp_plo_next = pmag[17:0] * recip_reg;
        pp_phi_next = pmag[PACC_W-1:18] * recip_reg;
        pp_alo_next = amag[19:0] * freq_reg;
        pp_ahi_next = amag[AACC_W-1:20] * freq_reg;
    end

    // Final stage F3: recombine, round and restore the sign
    logic [67:0]        pos_full;
    logic [70:0]        acc_full;
    logic [52:0]        pos_mag;
    logic [55:0]        acc_mag;
    logic signed [52:0] f3_pos_next;
    logic signed [55:0] f3_acc_next;

    always_comb
    begin
        pos_full    = (68'(f2_pp_phi_reg) << 18) + 68'(f2_pp_plo_reg) + 68'd32768;
        acc_full    = (71'(f2_pp_ahi_reg) << 20) + 71'(f2_pp_alo_reg) + 71'd32768;
        pos_mag     = {1'b0, pos_full[67:16]};
        acc_mag     = {1'b0, acc_full[70:16]};
        f3_pos_next = f2_pneg_reg ? -signed'(pos_mag) : signed'(pos_mag);
        f3_acc_next = f2_aneg_reg ? -signed'(acc_mag) : signed'(acc_mag);
    end

    // Output stage: add the start position and saturate
    logic signed [53:0] pos_total;
    out_item_t          out_next;

    always_comb
    begin
        pos_total             = 54'(q0_reg[f3_j_reg]) + 54'(f3_pos_reg);
        out_next.out_joint    = f3_j_reg;
        out_next.position     = sat_value(64'(pos_total));
        out_next.velocity     = f3_vel_reg;
        out_next.acceleration = sat_value(64'(f3_acc_reg));
        out_next.last         = f3_last_reg;
    end

    // Valid bits of every stage, frozen while the output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            f3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            f1_valid_reg  <= s5_valid_reg && s5_ctl_reg.last_h;
            f2_valid_reg  <= f1_valid_reg;
            f3_valid_reg  <= f2_valid_reg;
            out_valid_reg <= f3_valid_reg;
        end
    end

    // Data path registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctl_reg  <= issue_ctl;
            s1_ph_reg   <= ph_full[PHASE_BITS-1:0];
            s1_a_ok_reg <= sin_ok_reg[{j_reg, h_reg}];
            s1_b_ok_reg <= cos_ok_reg[{j_reg, h_reg}];

            s2_ctl_reg <= s1_ctl_reg;
            s2_s_reg   <= s2_s_next;
            s2_c_reg   <= s2_c_next;
            s2_a_reg   <= s2_a_next;
            s2_b_reg   <= s2_b_next;

            s3_ctl_reg <= s2_ctl_reg;
            s3_as_reg  <= by_trig(s2_a_reg, s2_s_reg);
            s3_bc_reg  <= by_trig(s2_b_reg, s2_c_reg);
            s3_ac_reg  <= by_trig(s2_a_reg, s2_c_reg);
            s3_bs_reg  <= by_trig(s2_b_reg, s2_s_reg);

            s4_ctl_reg <= s3_ctl_reg;
            s4_d_reg   <= s4_d_next;
            s4_v_reg   <= s4_v_next;

            s5_ctl_reg <= s4_ctl_reg;
            s5_p_reg   <= s5_p_next;
            s5_v_reg   <= s4_v_reg;
            s5_a_reg   <= s5_a_next;

            if (s5_valid_reg)
            begin
                pos_acc_reg <= pos_acc_next;
                vel_acc_reg <= vel_acc_next;
                acc_acc_reg <= acc_acc_next;
                f1_j_reg    <= s5_ctl_reg.joint;
                f1_last_reg <= s5_ctl_reg.last_j;
            end

            f2_j_reg      <= f1_j_reg;
            f2_last_reg   <= f1_last_reg;
            f2_pneg_reg   <= pos_acc_reg[PACC_W-1];
            f2_aneg_reg   <= acc_acc_reg[AACC_W-1];
            f2_pp_plo_reg <= pp_plo_next;
            f2_pp_phi_reg <= pp_phi_next;
            f2_pp_alo_reg <= pp_alo_next;
            f2_pp_ahi_reg <= pp_ahi_next;
            f2_vel_reg    <= sat_value(64'(vel_acc_reg));

            f3_j_reg    <= f2_j_reg;
            f3_last_reg <= f2_last_reg;
            f3_vel_reg  <= f2_vel_reg;
            f3_pos_reg  <= f3_pos_next;
            f3_acc_reg  <= f3_acc_next;

            if (f3_valid_reg)
                out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // No request is taken while terms are still being issued.
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_RUN) |-> !in_ready)
        else $error("request accepted while the sequencer is running");

    // An accepted evaluate request starts the sequencer on the next cycle.
    a_eval_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        eval_accept |=> (state_reg == SEQ_RUN))
        else $error("evaluate request did not start the sequencer");

    // The last flag marks exactly the final joint in use.
    a_last_matches_joint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        (out_data_reg.last == ({1'b0, out_data_reg.out_joint} ==
                               COUNT_W'(nj_lim - COUNT_W'(1)))))
        else $error("last flag does not match the final joint");

    // A stalled output freezes the term pipeline.
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s5_valid_reg) && $stable(f3_valid_reg))
        else $error("pipeline moved during an output stall");
`endif

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for fourier_trajectory_evaluator_top: directed table, then random requests.
// Results are checked against an in-bench predictor of the Fourier series sums.
// Depends on fte_pkg and the evaluator RTL.
`timescale 1ns / 1ps

module tb_top;
    import fte_pkg::*;

    localparam longint unsigned WIDE_CLAMP = 64'd1 << 60;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 120;

    logic clk;
    logic rst_n;
    logic cfg_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FREQ_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;

    fourier_trajectory_evaluator_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // Predictor state: configuration, coefficient stores and trig table
    logic [3:0] joints_cfg;
    logic [3:0] harmonics_cfg;
    logic [30:0] omega_cfg;
    logic [30:0] inv_omega_cfg;
    logic signed [31:0] sin_coef [MAX_JOINTS * MAX_HARMONICS];
    logic signed [31:0] cos_coef [MAX_JOINTS * MAX_HARMONICS];
    logic signed [31:0] start_pos [MAX_JOINTS];
    longint unsigned quarter_wave [65];

    out_item_t pending_results [$];
    int errors;
    int cycles;
    // Raised by the stimulus to ask the receiver for one long hold-off
    bit hold_request;

    // Directed stimulus row; a typed row carries the position, velocity and
    // acceleration that every joint must report.
    typedef struct {
        in_item_t req;
        bit typed;
        logic signed [31:0] t_pos;
        logic signed [31:0] t_vel;
        logic signed [31:0] t_acc;
    } stim_row_t;

    // Configuration settings used for successive phases of the run
    typedef struct {
        logic [3:0] nj;
        logic [3:0] nh;
        logic [30:0] w;
        logic [30:0] inv_w;
    } cfg_set_t;

    function automatic in_item_t make_req(logic [1:0] k, int j, int h, int v, int p);
        in_item_t r;
        r.kind = k;
        r.joint = j[2:0];
        r.harmonic = h[2:0];
        r.load_value = v;
        r.phase = p[15:0];
        return r;
    endfunction

    // Quarter-wave sine samples, Taylor series in Q30 rounded to Q16
    task automatic fill_quarter_wave();
        longint unsigned x, sq, t;
        for (int k = 0; k <= 64; k++)
        begin
            x = (longint'(k) * 64'd3373259426) >> 7;
            sq = (x * x) >> 30;
            t = 64'd1 << 30;
            for (int n = 7; n >= 1; n--)
            begin
                t = (64'd1 << 30) - (((sq * t) >> 30) / longint'((2 * n) * (2 * n + 1)));
            end
            quarter_wave[k] = (((x * t) >> 30) + 64'd8192) >> 14;
        end
    endtask

    function automatic int trig_sample(logic [15:0] p);
        logic [7:0] idx;
        logic [7:0] frac;
        int i;
        longint unsigned a, b, v;
        idx = p[15:8];
        frac = p[7:0];
        i = idx[5:0];
        if (idx[6])
        begin
            a = quarter_wave[64 - i];
            b = quarter_wave[63 - i];
        end
        else
        begin
            a = quarter_wave[i];
            b = quarter_wave[i + 1];
        end
        v = (a * (256 - frac) + b * frac + 128) >> 8;
        return idx[7] ? -int'(v) : int'(v);
    endfunction

    // Rounded product a*b/2^16, halves away from zero, magnitude clamped
    function automatic longint mul_q16(longint a, longint unsigned b);
        bit neg;
        longint unsigned ua, hi, lo, bb, hp, r;
        neg = a < 0;
        ua = a;
        if (neg)
            ua = -ua;
        hi = ua >> 32;
        lo = ua & 64'hFFFF_FFFF;
        bb = b & 64'h7FFF_FFFF;
        hp = hi * bb;
        if (hp >= (WIDE_CLAMP >> 16))
            r = WIDE_CLAMP;
        else
        begin
            r = (hp << 16) + ((lo * bb + 64'd32768) >> 16);
            if (r > WIDE_CLAMP)
                r = WIDE_CLAMP;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint mul_trig(longint a, int s);
        longint r;
        r = mul_q16(a, (s < 0) ? -s : s);
        return (s < 0) ? -r : r;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Apply one accepted request: store a load, or queue the results of an evaluate
    task automatic predict_trajectory(in_item_t r, bit typed, logic signed [31:0] tp,
                                      logic signed [31:0] tv, logic signed [31:0] ta);
        int nj, nh, s, c, idx;
        longint pos, vel, acc, a, b, d;
        logic [15:0] ph;
        out_item_t res;
        if (r.kind != KIND_EVAL)
        begin
            if (r.kind == KIND_START)
                start_pos[r.joint] = r.load_value;
            else if (r.kind == KIND_SIN)
                sin_coef[{r.joint, r.harmonic}] = r.load_value;
            else
                cos_coef[{r.joint, r.harmonic}] = r.load_value;
            return;
        end
        nj = (joints_cfg < 1) ? 1 : (joints_cfg > MAX_JOINTS) ? MAX_JOINTS : joints_cfg;
        nh = (harmonics_cfg < 1) ? 1 : (harmonics_cfg > MAX_HARMONICS) ? MAX_HARMONICS
                                                                         : harmonics_cfg;
        for (int j = 0; j < nj; j++)
        begin
            pos = 0;
            vel = 0;
            acc = 0;
            for (int h = 1; h <= nh; h++)
            begin
                ph = 16'(h * r.phase);
                s = trig_sample(ph);
                c = trig_sample(ph + QUARTER_TURN);
                idx = j * MAX_HARMONICS + h - 1;
                a = sin_coef[idx];
                b = cos_coef[idx];
                d = mul_trig(a, s) - mul_trig(b, c);
                vel += mul_trig(a, c) + mul_trig(b, s);
                pos += mul_q16(d, (131072 + h) / (2 * h));
                acc -= longint'(h) * d;
            end
            res.out_joint = j[2:0];
            res.position = typed ? tp : clamp32(longint'(start_pos[j]) + mul_q16(pos, inv_omega_cfg));
            res.velocity = typed ? tv : clamp32(vel);
            res.acceleration = typed ? ta : clamp32(mul_q16(acc, omega_cfg));
            res.last = (j + 1 == nj);
            pending_results.insert(pending_results.size(), res);
        end
    endtask

    // Clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result checking against the oldest pending expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%t: unexpected result %p", $realtime, out_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.out_joint !== want.out_joint)
                begin
                    $display("%t: joint expected %0d actual %0d", $realtime,
                             want.out_joint, out_data.out_joint);
                    errors++;
                end
                if (out_data.position !== want.position)
                begin
                    $display("%t: position expected %0d actual %0d", $realtime,
                             want.position, out_data.position);
                    errors++;
                end
                if (out_data.velocity !== want.velocity)
                begin
                    $display("%t: velocity expected %0d actual %0d", $realtime,
                             want.velocity, out_data.velocity);
                    errors++;
                end
                if (out_data.acceleration !== want.acceleration)
                begin
                    $display("%t: acceleration expected %0d actual %0d", $realtime,
                             want.acceleration, out_data.acceleration);
                    errors++;
                end
                if (out_data.last !== want.last)
                begin
                    $display("%t: last expected %0b actual %0b", $realtime,
                             want.last, out_data.last);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off while requests keep coming,
    // so that the block backs up and stalls its input
    initial
    begin
        int stall;
        int roll;
        bit hold_done;
        stall = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                stall = 600;
                hold_done = 1'b1;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                roll = $urandom_range(99);
                if (roll < 25)
                    stall = $urandom_range(3, 1);
                else if (roll < 30)
                    stall = $urandom_range(15, 4);
                else if (roll < 31)
                    stall = $urandom_range(80, 30);
            end
        end
    end

    // Idle gap on the request side, called and left at a falling edge
    task automatic request_gap();
        int roll, n;
        roll = $urandom_range(99);
        n = (roll < 50) ? 0 : (roll < 85) ? $urandom_range(3, 1)
                        : (roll < 97) ? $urandom_range(15, 4) : $urandom_range(80, 30);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Offer one request and hold it until accepted; returns at a falling edge
    task automatic send_request(in_item_t r, bit typed, logic signed [31:0] tp,
                                logic signed [31:0] tv, logic signed [31:0] ta);
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (!in_ready);
        predict_trajectory(r, typed, tp, tv, ta);
        @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [FREQ_W-1:0] val);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        case (idx)
            CFG_JOINTS:    joints_cfg = val[3:0];
            CFG_HARMONICS: harmonics_cfg = val[3:0];
            CFG_FREQ:      omega_cfg = val;
            default:       inv_omega_cfg = val;
        endcase
    endtask

    function automatic int random_load_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        if (roll < 70)
        begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic in_item_t random_request();
        logic [1:0] k;
        k = ($urandom_range(99) < 40) ? KIND_EVAL : 2'($urandom_range(3, 1));
        return make_req(k, $urandom_range(7), $urandom_range(7), random_load_value(),
                        $urandom_range(16'hFFFF));
    endfunction

    // Wait for every pending result, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Stimulus: directed table, then random phases under several settings
    initial
    begin
        stim_row_t rows [$];
        cfg_set_t settings [$];
        cfg_set_t cs;
        errors = 0;
        hold_request = 1'b0;
        rst_n = 1'b0;
        cfg_en = 1'b0;
        cfg_index = CFG_JOINTS;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        joints_cfg = JOINTS_RESET;
        harmonics_cfg = HARMONICS_RESET;
        omega_cfg = FREQ_RESET;
        inv_omega_cfg = RECIP_RESET;
        foreach (sin_coef[i])
        begin
            sin_coef[i] = 0;
            cos_coef[i] = 0;
        end
        foreach (start_pos[i])
            start_pos[i] = 0;
        fill_quarter_wave();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);

        // Empty stores give zero at both phase extremes
        rows.insert(rows.size(), '{make_req(KIND_EVAL, 0, 0, 0, 0), 1, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_EVAL, 7, 7, -1, 16'hFFFF), 1, 0, 0, 0});
        // Extreme start positions and coefficients
        rows.insert(rows.size(),
                    '{make_req(KIND_START, 0, 0, 32'h7FFF_FFFF, 16'hFFFF), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_START, 5, 7, 32'h8000_0000, 0), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_START, 7, 0, 32'h0001_0000, 0), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_SIN, 0, 0, 32'h0001_0000, 0), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_COS, 0, 0, 32'h0001_0000, 0), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_SIN, 1, 4, 32'h7FFF_FFFF, 0), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_COS, 1, 4, 32'h8000_0000, 0), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_SIN, 7, 7, 32'h8000_0000, 0), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_COS, 7, 7, 32'h7FFF_FFFF, 0), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_SIN, 2, 1, -32'h0003_2000, 0), 0, 0, 0, 0});
        // Every quadrant boundary, neighbours of the wrap and mixed bit patterns
        rows.insert(rows.size(), '{make_req(KIND_EVAL, 0, 0, 0, 0), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_EVAL, 0, 0, 0, 16'h4000), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_EVAL, 0, 0, 0, 16'h8000), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_EVAL, 0, 0, 0, 16'hC000), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_EVAL, 0, 0, 0, 16'h0001), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_EVAL, 0, 0, 0, 16'hFFFF), 0, 0, 0, 0});
        rows.insert(rows.size(), '{make_req(KIND_EVAL, 0, 0, 0, 16'h5555), 0, 0, 0, 0});
        // Evaluate ignores joint, harmonic and value fields
        rows.insert(rows.size(),
                    '{make_req(KIND_EVAL, 7, 7, 32'h7FFF_FFFF, 16'hAAAA), 0, 0, 0, 0});

        foreach (rows[i])
        begin
            request_gap();
            send_request(rows[i].req, rows[i].typed, rows[i].t_pos, rows[i].t_vel,
                         rows[i].t_acc);
        end
        settle();

        // Settings per phase: maximum, minimum, zero with out-of-range counts, wide, random
        settings.insert(settings.size(), '{4'd8, 4'd8, 31'h7FFF_FFFF, 31'h7FFF_FFFF});
        settings.insert(settings.size(), '{4'd1, 4'd1, 31'd1, 31'd1});
        settings.insert(settings.size(), '{4'd0, 4'd0, 31'd0, 31'd0});
        settings.insert(settings.size(), '{4'd15, 4'd15, 31'd65536, 31'd65536});
        cs.nj = 4'($urandom_range(8, 1));
        cs.nh = 4'($urandom_range(8, 1));
        cs.w = 31'($urandom_range(32'h0010_0000, 1));
        cs.inv_w = 31'($urandom);
        settings.insert(settings.size(), cs);

        foreach (settings[p])
        begin
            write_cfg(CFG_JOINTS, 31'(settings[p].nj));
            write_cfg(CFG_HARMONICS, 31'(settings[p].nh));
            write_cfg(CFG_FREQ, settings[p].w);
            write_cfg(CFG_RECIP, settings[p].inv_w);
            cfg_en <= 1'b0;
            @(negedge clk);
            for (int n = 0; n < 46; n++)
            begin
                // Part way into the first phase the receiver holds off for a long time
                if (p == 0 && n == 10)
                    hold_request = 1'b1;
                request_gap();
                send_request(random_request(), 0, 0, 0, 0);
            end
            settle();
        end

        if (errors == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/fte_pkg.sv
rtl/core/fte_ram.sv
rtl/core/fourier_trajectory_evaluator_top.sv
test/tb_top.sv
